[hdl/frdr_pkg.sv]
// frdr_pkg: widths, constants and sideband types of the fresnel reflectance core
// used by the top level and bench files; no dependencies
package frdr_pkg;

   localparam int COS_W         = 16;
   localparam int INDEX_W       = 16;
   localparam int OUT_W         = 16;
   localparam int COS_FRAC_BITS = 14;
   localparam int OUT_FRAC_BITS = 15;
   localparam int WORK_BITS     = 30;
   localparam int RATIO_BITS    = 31;

   localparam int AC_W   = COS_FRAC_BITS + 1;
   localparam int ACSQ_W = 2 * COS_FRAC_BITS + 2;
   localparam int S2_W   = 2 * COS_FRAC_BITS + 1;
   localparam int S30_W  = WORK_BITS + 1;
   localparam int ISQ_W  = 2 * INDEX_W;
   localparam int LHS_W  = ISQ_W + S30_W;
   localparam int Q1_W   = WORK_BITS;
   localparam int RAD_W  = 2 * WORK_BITS + 1;
   localparam int CT_W   = WORK_BITS + 1;
   localparam int CI_W   = WORK_BITS + 1;
   localparam int PROD_W = INDEX_W + CI_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int RNUM_W = SUM_W + RATIO_BITS;
   localparam int RQ_W   = RATIO_BITS + 1;
   localparam int SQR_W  = 2 * RQ_W;
   localparam int AVG_W  = SQR_W - 1;
   localparam int RND_SH = 2 * RATIO_BITS - OUT_FRAC_BITS;
   localparam int RES_W  = AVG_W + 1 - RND_SH;

   localparam logic signed [COS_W-1:0] COS_ONE  = COS_W'(1 << COS_FRAC_BITS);
   localparam logic signed [COS_W-1:0] COS_MONE = -COS_ONE;
   localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1 << OUT_FRAC_BITS);
   localparam logic [INDEX_W-1:0] OUTSIDE_RESET = INDEX_W'(4096);
   localparam logic [INDEX_W-1:0] INSIDE_RESET  = INDEX_W'(6144);

   localparam logic [0:0] REG_OUTSIDE = 1'b0;
   localparam logic [0:0] REG_INSIDE  = 1'b1;

   typedef struct packed {
      logic               tir;
      logic [INDEX_W-1:0] ei;
      logic [INDEX_W-1:0] et;
      logic [CI_W-1:0]    ci;
   } mid_side_type;

   typedef struct packed {
      logic tir;
      logic den_zero;
   } par_side_type;

endpackage

[hdl/frdr_div.sv]
// frdr_div: pipelined restoring divider, one quotient bit per register stage
// depends on nothing; sideband bits travel alongside each item
module frdr_div #(
   parameter int NW = 63,
   parameter int DW = 32,
   parameter int QW = 30,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic [QW-1:0] quo,
   output logic [SW-1:0] side_out
);

   localparam int W = (NW > DW + QW) ? NW : DW + QW;

   logic [NW-1:0] r_ff [QW];
   logic [DW-1:0] d_ff [QW];
   logic [QW-1:0] q_ff [QW];
   logic [SW-1:0] s_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int SH = QW - 1 - i;
      logic [NW-1:0] r_src;
      logic [DW-1:0] d_src;
      logic [QW-1:0] q_src;
      logic [SW-1:0] s_src;
      logic [W-1:0]  trial;
      logic          take;
      logic [NW-1:0] r_in;
      logic [QW-1:0] q_in;

      if (i == 0) begin : g_first
         assign r_src = num;
         assign d_src = den;
         assign q_src = '0;
         assign s_src = side_in;
      end else begin : g_next
         assign r_src = r_ff[i-1];
         assign d_src = d_ff[i-1];
         assign q_src = q_ff[i-1];
         assign s_src = s_ff[i-1];
      end

      assign trial = W'(d_src) << SH;
      assign take  = W'(r_src) >= trial;
      assign r_in  = take ? NW'(W'(r_src) - trial) : r_src;
      assign q_in  = take ? (q_src | (QW'(1) << SH)) : q_src;

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i] <= r_in;
            d_ff[i] <= d_src;
            q_ff[i] <= q_in;
            s_ff[i] <= s_src;
         end
      end
   end

   assign quo      = q_ff[QW-1];
   assign side_out = s_ff[QW-1];

endmodule

[hdl/frdr_sqrt.sv]
// frdr_sqrt: pipelined integer square root (floor), one root bit per stage
// depends on nothing; sideband bits travel alongside each item
module frdr_sqrt #(
   parameter int VW = 61,
   parameter int RW = 31,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [VW-1:0] radicand,
   input  logic [SW-1:0] side_in,
   output logic [RW-1:0] root,
   output logic [SW-1:0] side_out
);

   localparam int TW = VW + 1;

   logic [VW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [SW-1:0] s_ff    [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      localparam int K = RW - 1 - i;
      logic [VW-1:0] rem_src;
      logic [RW-1:0] root_src;
      logic [SW-1:0] s_src;
      logic [TW-1:0] trial;
      logic          take;
      logic [VW-1:0] rem_in;
      logic [RW-1:0] root_in;

      if (i == 0) begin : g_first
         assign rem_src  = radicand;
         assign root_src = '0;
         assign s_src    = side_in;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign s_src    = s_ff[i-1];
      end

      assign trial   = (TW'(root_src) << (K + 1)) + (TW'(1) << (2 * K));
      assign take    = TW'(rem_src) >= trial;
      assign rem_in  = take ? VW'(TW'(rem_src) - trial) : rem_src;
      assign root_in = take ? (root_src | (RW'(1) << K)) : root_src;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            s_ff[i]    <= s_src;
         end
      end
   end

   assign root     = root_ff[RW-1];
   assign side_out = s_ff[RW-1];

endmodule

[hdl/fresnel_dielectric_reflectance_core.sv]
// fresnel_dielectric_reflectance_core: unpolarised fresnel reflectance pipeline
// depends on frdr_pkg, frdr_div and frdr_sqrt
//
// usage:
//   req channel carries one incident cosine per item (signed Q2.14); rsp
//   channel returns its reflectance (Q1.15) with the total internal
//   reflection flag on tuser. the csr port writes the two refractive
//   indices (index 0 outside, index 1 inside, unsigned Q4.12); write them
//   only while no item is in flight.
//   throughput is one item per cycle while not held: the snell quotient, the square root
//   and both amplitude ratios are pipelined one result bit per stage.
//   when rsp_tready is low the two-entry output buffer keeps taking items
//   until it is full, after which the whole pipeline holds and req_tready
//   falls; nothing is dropped or repeated.
//   reset clears all valid bits and the output buffer and sets the indices
//   to 1.0 outside and 1.5 inside.
module fresnel_dielectric_reflectance_core
   import frdr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [INDEX_W-1:0] csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [COS_W-1:0]   req_tdata,   // cos_incident
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [OUT_W-1:0]   rsp_tdata,   // reflectance
   output logic [0:0]         rsp_tuser    // total_internal
);

   localparam int LAT = 4 + Q1_W + CT_W + 2 + RQ_W + 2;

   logic [INDEX_W-1:0] outside_ff, inside_ff;
   logic               en;
   logic [LAT-1:0]     v_ff, v_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         outside_ff <= OUTSIDE_RESET;
         inside_ff  <= INSIDE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OUTSIDE: outside_ff <= csr_wdata;
            REG_INSIDE:  inside_ff  <= csr_wdata;
         endcase
      end
   end

   assign v_in = {v_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // clamp, direction and index swap
   logic signed [COS_W-1:0] c_raw, c_cl;
   logic [AC_W-1:0]    f1_ac_ff, f1_ac_in;
   logic [INDEX_W-1:0] f1_ei_ff, f1_ei_in, f1_et_ff, f1_et_in;

   always_comb begin
      c_raw = signed'(req_tdata);
      if (c_raw > COS_ONE) begin
         c_cl = COS_ONE;
      end else if (c_raw < COS_MONE) begin
         c_cl = COS_MONE;
      end else begin
         c_cl = c_raw;
      end
      f1_ac_in = (c_cl < 0) ? AC_W'(-c_cl) : AC_W'(c_cl);
      f1_ei_in = (c_cl > 0) ? outside_ff : inside_ff;
      f1_et_in = (c_cl > 0) ? inside_ff : outside_ff;
   end

   // squares of cosine and indices
   logic [ACSQ_W-1:0]  f2_acsq;
   logic [S2_W-1:0]    f2_s2;
   logic [S30_W-1:0]   f2_s30_ff, f2_s30_in;
   logic [ISQ_W-1:0]   f2_ei2_ff, f2_ei2_in, f2_et2_ff, f2_et2_in;
   logic [INDEX_W-1:0] f2_ei_ff, f2_et_ff;
   logic [CI_W-1:0]    f2_ci_ff, f2_ci_in;

   always_comb begin
      f2_acsq   = f1_ac_ff * f1_ac_ff;
      f2_s2     = S2_W'((ACSQ_W'(1) << (2 * COS_FRAC_BITS)) - f2_acsq);
      f2_s30_in = S30_W'(f2_s2) << (WORK_BITS - 2 * COS_FRAC_BITS);
      f2_ei2_in = f1_ei_ff * f1_ei_ff;
      f2_et2_in = f1_et_ff * f1_et_ff;
      f2_ci_in  = CI_W'(f1_ac_ff) << (WORK_BITS - COS_FRAC_BITS);
   end

   // snell left-hand side
   logic [LHS_W-1:0]   f3_lhs_ff, f3_lhs_in;
   logic [ISQ_W-1:0]   f3_et2_ff;
   logic [INDEX_W-1:0] f3_ei_ff, f3_et_ff;
   logic [CI_W-1:0]    f3_ci_ff;

   assign f3_lhs_in = f2_ei2_ff * f2_s30_ff;

   // total internal reflection test
   logic [LHS_W-1:0] f4_lhs_ff;
   logic [ISQ_W-1:0] f4_et2_ff;
   mid_side_type     f4_side_ff, f4_side_in;

   always_comb begin
      f4_side_in.tir = f3_lhs_ff >= LHS_W'({f3_et2_ff, WORK_BITS'(0)});
      f4_side_in.ei  = f3_ei_ff;
      f4_side_in.et  = f3_et_ff;
      f4_side_in.ci  = f3_ci_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ac_ff   <= f1_ac_in;
         f1_ei_ff   <= f1_ei_in;
         f1_et_ff   <= f1_et_in;
         f2_s30_ff  <= f2_s30_in;
         f2_ei2_ff  <= f2_ei2_in;
         f2_et2_ff  <= f2_et2_in;
         f2_ei_ff   <= f1_ei_ff;
         f2_et_ff   <= f1_et_ff;
         f2_ci_ff   <= f2_ci_in;
         f3_lhs_ff  <= f3_lhs_in;
         f3_et2_ff  <= f2_et2_ff;
         f3_ei_ff   <= f2_ei_ff;
         f3_et_ff   <= f2_et_ff;
         f3_ci_ff   <= f2_ci_ff;
         f4_lhs_ff  <= f3_lhs_ff;
         f4_et2_ff  <= f3_et2_ff;
         f4_side_ff <= f4_side_in;
      end
   end

   // sin_t squared, then cos_t
   logic [Q1_W-1:0]  d1_quo;
   mid_side_type     d1_side, sq_side;
   logic [RAD_W-1:0] sq_rad;
   logic [CT_W-1:0]  sq_root;

   frdr_div #(
      .NW(LHS_W), .DW(ISQ_W), .QW(Q1_W), .SW($bits(mid_side_type))
   ) u_snell_div (
      .clock    (clock),
      .en       (en),
      .num      (f4_lhs_ff),
      .den      (f4_et2_ff),
      .side_in  (f4_side_ff),
      .quo      (d1_quo),
      .side_out (d1_side)
   );

   assign sq_rad = {CT_W'((CT_W'(1) << WORK_BITS) - CT_W'(d1_quo)), WORK_BITS'(0)};

   frdr_sqrt #(
      .VW(RAD_W), .RW(CT_W), .SW($bits(mid_side_type))
   ) u_cos_root (
      .clock    (clock),
      .en       (en),
      .radicand (sq_rad),
      .side_in  (d1_side),
      .root     (sq_root),
      .side_out (sq_side)
   );

   // amplitude ratio terms
   logic [PROD_W-1:0] m1_a1_ff, m1_b1_ff, m1_a2_ff, m1_b2_ff;
   logic              m1_tir_ff;
   logic [SUM_W-1:0]  m2_np_ff, m2_np_in, m2_dp_ff, m2_dp_in;
   logic [SUM_W-1:0]  m2_ns_ff, m2_ns_in, m2_ds_ff, m2_ds_in;
   logic              m2_tir_ff;

   always_comb begin
      m2_np_in = (m1_a1_ff > m1_b1_ff) ? SUM_W'(m1_a1_ff - m1_b1_ff)
                                       : SUM_W'(m1_b1_ff - m1_a1_ff);
      m2_dp_in = SUM_W'(m1_a1_ff) + SUM_W'(m1_b1_ff);
      m2_ns_in = (m1_a2_ff > m1_b2_ff) ? SUM_W'(m1_a2_ff - m1_b2_ff)
                                       : SUM_W'(m1_b2_ff - m1_a2_ff);
      m2_ds_in = SUM_W'(m1_a2_ff) + SUM_W'(m1_b2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_a1_ff  <= sq_side.et * sq_side.ci;
         m1_b1_ff  <= sq_side.ei * sq_root;
         m1_a2_ff  <= sq_side.ei * sq_side.ci;
         m1_b2_ff  <= sq_side.et * sq_root;
         m1_tir_ff <= sq_side.tir;
         m2_np_ff  <= m2_np_in;
         m2_dp_ff  <= m2_dp_in;
         m2_ns_ff  <= m2_ns_in;
         m2_ds_ff  <= m2_ds_in;
         m2_tir_ff <= m1_tir_ff;
      end
   end

   par_side_type    par_side_in, par_side;
   logic [0:0]      perp_zero_in, perp_zero;
   logic [RQ_W-1:0] qp, qs;

   assign par_side_in.tir      = m2_tir_ff;
   assign par_side_in.den_zero = (m2_dp_ff == '0);
   assign perp_zero_in         = (m2_ds_ff == '0);

   frdr_div #(
      .NW(RNUM_W), .DW(SUM_W), .QW(RQ_W), .SW($bits(par_side_type))
   ) u_par_div (
      .clock    (clock),
      .en       (en),
      .num      ({m2_np_ff, RATIO_BITS'(0)}),
      .den      (m2_dp_ff),
      .side_in  (par_side_in),
      .quo      (qp),
      .side_out (par_side)
   );

   frdr_div #(
      .NW(RNUM_W), .DW(SUM_W), .QW(RQ_W), .SW(1)
   ) u_perp_div (
      .clock    (clock),
      .en       (en),
      .num      ({m2_ns_ff, RATIO_BITS'(0)}),
      .den      (m2_ds_ff),
      .side_in  (perp_zero_in),
      .quo      (qs),
      .side_out (perp_zero)
   );

   // squares, average, rounding and saturation
   logic [RQ_W-1:0]  rp, rs;
   logic [SQR_W-1:0] p2_sqp_ff, p2_sqs_ff, p2_sum;
   logic             p2_tir_ff;
   logic [AVG_W-1:0] p2_avg;
   logic [RES_W-1:0] p2_res;
   logic [OUT_W-1:0] r_refl_ff, r_refl_in;
   logic             r_tir_ff;

   assign rp = par_side.den_zero ? (RQ_W'(1) << RATIO_BITS) : qp;
   assign rs = perp_zero[0] ? (RQ_W'(1) << RATIO_BITS) : qs;

   always_comb begin
      p2_sum = p2_sqp_ff + p2_sqs_ff;
      p2_avg = AVG_W'(p2_sum >> 1);
      p2_res = RES_W'((SQR_W'(p2_avg) + (SQR_W'(1) << (RND_SH - 1))) >> RND_SH);
      if (p2_tir_ff || (p2_res > RES_W'(OUT_ONE))) begin
         r_refl_in = OUT_ONE;
      end else begin
         r_refl_in = OUT_W'(p2_res);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_sqp_ff <= rp * rp;
         p2_sqs_ff <= rs * rs;
         p2_tir_ff <= par_side.tir;
         r_refl_ff <= r_refl_in;
         r_tir_ff  <= p2_tir_ff;
      end
   end

   // two-entry output buffer
   logic [OUT_W:0] buf_ff [2];
   logic [1:0]     cnt_ff, cnt_in;
   logic           wr_ptr_ff, rd_ptr_ff;
   logic           push, pop;

   assign en     = (cnt_ff != 2'd2) || rsp_tready;
   assign push   = v_ff[LAT-1] && en;
   assign pop    = rsp_tvalid && rsp_tready;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= {r_tir_ff, r_refl_ff};
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = buf_ff[rd_ptr_ff][OUT_W-1:0];
   assign rsp_tuser  = buf_ff[rd_ptr_ff][OUT_W];

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("output buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && cnt_ff == 2'd2))
      else $error("item pushed into full output buffer");

   a_tir_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == OUT_ONE)
      else $error("total internal reflection without full reflectance");

   a_refl_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= OUT_ONE)
      else $error("reflectance above one");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule

[bench/tb_fresnel_dielectric_reflectance_core.sv]
// tb_fresnel_dielectric_reflectance_core: self-checking bench for the fresnel reflectance core
// drives incident cosines under several index settings and checks each reflectance and tir flag
// depends on frdr_pkg and fresnel_dielectric_reflectance_core
module tb_fresnel_dielectric_reflectance_core;
   import frdr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 101;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [OUT_W-1:0] reflectance;
      logic             tir;
   } reflect_item_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [0:0]         csr_index;
   logic [INDEX_W-1:0] csr_wdata;
   logic               req_tvalid;
   logic               req_tready;
   logic [COS_W-1:0]   req_tdata;   // cos_incident
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [OUT_W-1:0]   rsp_tdata;   // reflectance
   logic [0:0]         rsp_tuser;   // total_internal

   logic [INDEX_W-1:0] n_outside;
   logic [INDEX_W-1:0] n_inside;
   reflect_item_type   expected_q[$];
   int                 mismatches;
   int                 idle_cycles;
   bit                 hold_rsp;
   bit                 rsp_gaps_on;

   fresnel_dielectric_reflectance_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] amp_ratio(logic [63:0] n, logic [63:0] d);
      logic [127:0] w;
      if (d == 0) return 64'd1 << RATIO_BITS;
      w = {64'd0, n} << RATIO_BITS;
      return 64'(w / d);
   endfunction

   function automatic reflect_item_type fresnel_of(logic [COS_W-1:0] raw);
      reflect_item_type r;
      logic signed [31:0] c;
      logic [63:0] ei, et, ac, s30, lhs, rhs, q, ct, ci, a, b;
      logic [63:0] np, dp, ns, ds, rp, rs, avg, res;
      c = 32'($signed(raw));
      if (c > (1 << COS_FRAC_BITS)) c = 1 << COS_FRAC_BITS;
      if (c < -(1 << COS_FRAC_BITS)) c = -(1 << COS_FRAC_BITS);
      if (c > 0) begin
         ei = 64'(n_outside);
         et = 64'(n_inside);
      end else begin
         ei = 64'(n_inside);
         et = 64'(n_outside);
      end
      ac = (c < 0) ? 64'(-c) : 64'(c);
      s30 = ((64'd1 << (2 * COS_FRAC_BITS)) - ac * ac) << (WORK_BITS - 2 * COS_FRAC_BITS);
      lhs = ei * ei * s30;
      rhs = (et * et) << WORK_BITS;
      if (lhs >= rhs) begin
         r.reflectance = OUT_ONE;
         r.tir = 1'b1;
         return r;
      end
      q = lhs / (et * et);
      ct = isqrt(((64'd1 << WORK_BITS) - q) << WORK_BITS);
      ci = ac << (WORK_BITS - COS_FRAC_BITS);
      a = et * ci;
      b = ei * ct;
      np = (a > b) ? a - b : b - a;
      dp = a + b;
      a = ei * ci;
      b = et * ct;
      ns = (a > b) ? a - b : b - a;
      ds = a + b;
      rp = amp_ratio(np, dp);
      rs = amp_ratio(ns, ds);
      avg = (rp * rp + rs * rs) >> 1;
      res = (avg + (64'd1 << (RND_SH - 1))) >> RND_SH;
      if (res > OUT_ONE) res = OUT_ONE;
      r.reflectance = res[OUT_W-1:0];
      r.tir = 1'b0;
      return r;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 99) < 60) return 0;
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_cosine(logic [COS_W-1:0] v, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(fresnel_of(v));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_index(logic [0:0] idx, logic [INDEX_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_OUTSIDE) n_outside = v;
      else n_inside = v;
      @(negedge clock);
   endtask

   task automatic test_directed();
      logic [COS_W-1:0] pts[$];
      pts = '{16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h4001, 16'hBFFF, 16'h0000,
              16'h0001, 16'hFFFF, 16'h2000, 16'hE000, 16'h3FFF, 16'hC001, 16'h5555,
              16'hAAAA, 16'h0100, 16'hFF00};
      foreach (pts[i]) send_cosine(pts[i], 1'b0);
      drain();
   endtask

   task automatic test_random_cosines(int count);
      logic [COS_W-1:0] v;
      repeat (count) begin
         case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 16384));
            2: v = 16'(0 - $urandom_range(0, 16384));
            default: begin
               v = 16'($urandom_range(0, 64));
               v ^= ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
            end
         endcase
         send_cosine(v, 1'b1);
      end
   endtask

   task automatic test_index_sweep();
      logic [INDEX_W-1:0] pairs[$];
      pairs = '{16'd1024, 16'd65535, 16'd65535, 16'd1024, 16'd4096, 16'd4096,
                16'd1024, 16'd1024, 16'd65535, 16'd65535, 16'd6144, 16'd4096};
      for (int i = 0; i < pairs.size(); i += 2) begin
         write_index(REG_OUTSIDE, pairs[i]);
         write_index(REG_INSIDE, pairs[i+1]);
         test_random_cosines(80);
         drain();
      end
      repeat (6) begin
         write_index(REG_OUTSIDE, 16'($urandom_range(1024, 65535)));
         write_index(REG_INSIDE, 16'($urandom_range(1024, 65535)));
         test_random_cosines(110);
         drain();
      end
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         test_random_cosines(200);
      join
      drain();
   endtask

   task automatic test_full_rate();
      rsp_gaps_on = 1'b0;
      repeat (200) send_cosine(16'($urandom), 1'b0);
      rsp_gaps_on = 1'b1;
      drain();
   endtask

   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else if (!rsp_gaps_on) rsp_tready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) < 75);
   end

   always @(posedge clock) begin
      reflect_item_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h/%b", rsp_tdata, rsp_tuser);
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata !== e.reflectance || rsp_tuser[0] !== e.tir) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %h/%b got %h/%b", e.reflectance, e.tir,
                           rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      mismatches  = 0;
      idle_cycles = 0;
      hold_rsp    = 1'b0;
      rsp_gaps_on = 1'b1;
      n_outside   = OUTSIDE_RESET;
      n_inside    = INSIDE_RESET;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = REG_OUTSIDE;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_cosines(330);
      drain();
      test_backpressure();
      test_full_rate();
      test_index_sweep();
      write_index(REG_OUTSIDE, 16'd5000);
      write_index(REG_INSIDE, 16'd4096);
      test_directed();
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
